// ===== rtl/vfcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vfcm_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // opcodes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // blend modes (code 3 acts as crossfade)
  localparam logic [MODE_W-1:0] MODE_CROSS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FADE_IN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FADE_OUT = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE        = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COUNT = 1'b1;

  localparam logic [INDEX_W-1:0] FRAME_COUNT_RST = 16'd30;

  typedef struct packed {
    logic              opcode;
    logic [INDEX_W-1:0] frame_index;
    logic [CHAN_W-1:0] incoming_red;
    logic [CHAN_W-1:0] incoming_green;
    logic [CHAN_W-1:0] incoming_blue;
    logic [CHAN_W-1:0] outgoing_red;
    logic [CHAN_W-1:0] outgoing_green;
    logic [CHAN_W-1:0] outgoing_blue;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mixed_red;
    logic [CHAN_W-1:0] mixed_green;
    logic [CHAN_W-1:0] mixed_blue;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic pix_load;    // capture blended pixel into output register
    logic weight_one;  // saturate weight to 1.0
    logic div_start;   // load divider with frame index
    logic div_step;    // one restoring-division step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sat;       // index >= count, or count == 0
    logic div_last;  // current step is the final one
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/vfcm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vfcm_ctrl
  import vfcm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_opcode_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    accept      = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept && in_opcode_i == OP_PIXEL) begin
          cmd_o.pix_load = 1'b1;
          out_valid_d    = 1'b1;
        end else if (accept) begin
          if (status_i.sat) begin
            cmd_o.weight_one = 1'b1;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_pix_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pix_load |-> (state_q == ST_IDLE))
    else $error("pixel captured while dividing");

  a_div_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == ST_DIVIDE))
    else $error("divider start did not enter divide state");

  a_no_div_on_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.sat)
    else $error("division started for a saturated index");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");

endmodule
`default_nettype wire

// ===== rtl/vfcm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vfcm_datapath
  import vfcm_pkg::*;
#(
  parameter int unsigned WEIGHT_FRACTION_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire in_word_t              in_word_i,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  output out_word_t                  out_word_o
);

  localparam int unsigned WF    = WEIGHT_FRACTION_BITS;
  localparam int unsigned WW    = WF + 1;
  localparam int unsigned CNT_W = $clog2(WF);
  localparam int unsigned SUM_W = WF + CHAN_W + 3;

  // configuration
  logic [MODE_W-1:0]  mode_q;
  logic [INDEX_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CROSS;
      count_q <= FRAME_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:        mode_q  <= cfg_data_i[MODE_W-1:0];
        REG_FRAME_COUNT: count_q <= cfg_data_i[INDEX_W-1:0];
        default:         ;
      endcase
    end
  end

  // restoring divider: one quotient bit per cycle
  logic [INDEX_W-1:0] rem_q, rem_d;
  logic [WF-1:0]      quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [INDEX_W:0]   rem2;
  logic               ge;
  logic [WW-1:0]      weight_q;

  assign rem2  = {rem_q, 1'b0};
  assign ge    = rem2 >= {1'b0, count_q};
  assign rem_d = ge ? INDEX_W'(rem2 - {1'b0, count_q}) : rem2[INDEX_W-1:0];
  assign quo_d = {quo_q[WF-2:0], ge};

  assign status_o.sat      = (count_q == '0) || (in_word_i.frame_index >= count_q);
  assign status_o.div_last = (cnt_q == CNT_W'(WF - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= in_word_i.frame_index;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= '0;
    end else if (cmd_i.weight_one) begin
      weight_q <= {1'b1, {WF{1'b0}}};
    end else if (cmd_i.div_step && status_o.div_last) begin
      weight_q <= {1'b0, quo_d};
    end
  end

  // blend lanes: outg*2^F + w*(inc - outg)
  logic [CHAN_W-1:0] inc   [3];
  logic [CHAN_W-1:0] outg  [3];
  logic [CHAN_W-1:0] mixed [3];
  out_word_t         out_q;

  assign inc[0]  = in_word_i.incoming_red;
  assign inc[1]  = in_word_i.incoming_green;
  assign inc[2]  = in_word_i.incoming_blue;
  assign outg[0] = in_word_i.outgoing_red;
  assign outg[1] = in_word_i.outgoing_green;
  assign outg[2] = in_word_i.outgoing_blue;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [CHAN_W-1:0]       inc_m, outg_m;
    logic signed [CHAN_W:0]  diff;
    logic signed [SUM_W-1:0] diff_x, w_x, prod, base, sum;

    always_comb begin
      inc_m  = inc[c];
      outg_m = outg[c];
      case (mode_q)
        MODE_FADE_IN:  outg_m = '0;
        MODE_FADE_OUT: inc_m  = '0;
        default:       ;
      endcase
    end

    assign diff   = $signed({1'b0, inc_m}) - $signed({1'b0, outg_m});
    assign diff_x = SUM_W'(diff);
    assign w_x    = $signed({{(SUM_W-WW){1'b0}}, weight_q});
    assign prod   = w_x * diff_x;
    assign base   = $signed({{(SUM_W-CHAN_W-WF){1'b0}}, outg_m, {WF{1'b0}}});
    assign sum    = base + prod;
    assign mixed[c] = sum[WF +: CHAN_W];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      out_q.mixed_red   <= mixed[0];
      out_q.mixed_green <= mixed[1];
      out_q.mixed_blue  <= mixed[2];
    end
  end

  assign out_word_o = out_q;

endmodule
`default_nettype wire

// ===== rtl/video_fade_crossfade_mixer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake              Word
// --------  ---  ---------------------  -------------------------------------
// in        in   in_valid_i/in_ready_o  in_word_t: opcode, index, 2x RGB
// out       out  out_valid_o/out_ready_i out_word_t: mixed RGB
// cfg       in   cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// Pixel words: accepted back to back; result appears in the output
//   register the cycle after acceptance and is held until taken.
// Frame-start words: the weight is set to 1.0 if the index saturates it,
//   otherwise it is set by the one-bit-per-cycle divider.
// in_ready_o stays low while dividing and while a result waits with
//   out_ready_i low; a held result never blocks a frame-start already inside.
// Reset (async, active low): weight 0, mode crossfade, frame count 30.
module video_fade_crossfade_mixer_top
  import vfcm_pkg::*;
#(
  parameter int unsigned WEIGHT_FRACTION_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_word_t              in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_word_t                  out_word_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer: idle / divide, output valid flag
  vfcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_word_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // registers, weight divider, three blend lanes, output register
  vfcm_datapath #(
    .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire
